[rtl/combination_unrank_decoder_unit_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef COMBINATION_UNRANK_DECODER_UNIT_MACROS_SVH
`define COMBINATION_UNRANK_DECODER_UNIT_MACROS_SVH

// implication checked in the same cycle, off while reset is high
`define CUD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked at the next clock, off while reset is high
`define CUD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication that also holds around reset
`define CUD_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/cud_pkg.sv]
// widths, register indexes and reset values of the combination unrank decoder
// no dependencies
package cud_pkg;

   localparam int VAL_W      = 30;  // code and binomial width
   localparam int ELEM_W     = 6;
   localparam int N_W        = 6;
   localparam int K_W        = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_SET_SIZE   = 2'd0;
   localparam csr_index_type CSR_PICK_COUNT = 2'd1;

   localparam logic [N_W-1:0] SET_SIZE_RST   = 6'd32;
   localparam logic [K_W-1:0] PICK_COUNT_RST = 5'd16;

endpackage

[rtl/combination_unrank_decoder_unit.sv]
// combination unrank decoder: code in, ascending subset elements out
// depends on cud_pkg; binomial rows held in an internal memory
//
//  channel | direction | transfer moves
//  req_    | in        | code, the rank to decode
//  rsp_    | out       | one element of the subset, last flag, bad_input flag
//  csr_    | in        | register index and write data (set_size, pick_count)
//
// after reset a fill pass writes Pascal rows 0..MAX_N into the row memory, one row
// a cycle, and req_ready stays low until it ends; csr writes are taken throughout.
// a code is set up in the idle and check states (rank against C(n, k)), then the walk
// state examines the candidate elements in ascending order, one row read per cycle.
// a rejected code gives a single error transfer, from the error state.
// a stalled rsp_ holds the walk only when a new element is due.
module combination_unrank_decoder_unit #(
   parameter int MAX_N = 32,
   parameter int MAX_K = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cud_pkg::VAL_W-1:0]         req_code,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cud_pkg::ELEM_W-1:0]        rsp_element,
   output logic                              rsp_last,
   output logic                              rsp_bad_input,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cud_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cud_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cud_pkg::*;

   localparam int AW = $clog2(MAX_N + 1);
   localparam int RW = $clog2(MAX_K + 1);

   localparam logic [2:0] ST_FILL  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_ERR   = 3'd4;

   typedef logic [MAX_K:0][VAL_W-1:0] row_type;

   // row 0 of the triangle: C(0, 0) = 1, the rest zero
   localparam row_type PAS_ROW0 = row_type'(1);

   // row m holds C(m, r) for r = 0..MAX_K
   row_type            mem [0:MAX_N];
   row_type            rd_row_ff;
   logic [AW-1:0]      rd_addr;

   logic [2:0]         state_ff, state_in;
   logic [N_W-1:0]     set_size_ff, set_size_in;
   logic [K_W-1:0]     pick_count_ff, pick_count_in;
   logic [AW-1:0]      fill_cnt_ff, fill_cnt_in;
   row_type            pas_ff, pas_in;
   logic [AW-1:0]      n_ff, n_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [RW-1:0]      r_ff, r_in;
   logic [VAL_W-1:0]   e_ff, e_in;
   logic               bad_ff, bad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]  rsp_element_ff, rsp_element_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic               cfg_bad;
   logic [VAL_W-1:0]   cand;
   logic               j_lt_n;
   logic [AW-1:0]      j_next;
   logic               skip;
   logic               out_free;
   logic               fill_we;

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_element   = rsp_element_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_input = rsp_bad_ff;

   assign cfg_bad = (set_size_ff == '0) || (set_size_ff > N_W'(MAX_N))
                 || (pick_count_ff == '0) || (pick_count_ff > K_W'(MAX_K))
                 || ({1'b0, pick_count_ff} > set_size_ff);

   assign cand     = (r_ff <= RW'(MAX_K)) ? rd_row_ff[r_ff] : '0;
   assign j_lt_n   = (j_ff < n_ff);
   assign j_next   = j_lt_n ? j_ff + AW'(1) : j_ff;
   assign skip     = (cand > e_ff) && j_lt_n;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fill_we  = (state_ff == ST_FILL);

   // read address of the row the next cycle compares against
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            rd_addr = (set_size_ff > N_W'(MAX_N)) ? '0 : set_size_ff[AW-1:0];
         end
         ST_CHECK: begin
            rd_addr = bad_ff ? '0 : n_ff - AW'(1);
         end
         ST_WALK: begin
            rd_addr = (skip || out_free) ? n_ff - j_next : n_ff - j_ff;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // next Pascal row
   always_comb begin
      pas_in[0] = pas_ff[0];
      for (int r = 1; r <= MAX_K; r++) begin
         pas_in[r] = pas_ff[r] + pas_ff[r-1];
      end
   end

   // register writes
   always_comb begin
      set_size_in   = set_size_ff;
      pick_count_in = pick_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SET_SIZE:   set_size_in   = csr_wdata[N_W-1:0];
            CSR_PICK_COUNT: pick_count_in = csr_wdata[K_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      fill_cnt_in    = fill_cnt_ff;
      n_in           = n_ff;
      j_in           = j_ff;
      r_in           = r_ff;
      e_in           = e_ff;
      bad_in         = bad_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_bad_in     = rsp_bad_ff;

      case (state_ff)
         ST_FILL: begin
            fill_cnt_in = fill_cnt_ff + AW'(1);
            if (fill_cnt_ff == AW'(MAX_N)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               e_in     = req_code;
               bad_in   = cfg_bad;
               n_in     = cfg_bad ? '0 : set_size_ff[AW-1:0];
               r_in     = cfg_bad ? '0 : pick_count_ff[RW-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            j_in = AW'(1);
            // code must stay below C(n, k)
            if (bad_ff || (e_ff >= cand)) begin
               state_in = ST_ERR;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (skip) begin
               j_in = j_next;
            end else if (out_free) begin
               e_in           = e_ff - cand;
               j_in           = j_next;
               r_in           = r_ff - RW'(1);
               rsp_valid_in   = 1'b1;
               rsp_element_in = ELEM_W'(j_ff);
               rsp_last_in    = (r_ff == RW'(1));
               rsp_bad_in     = 1'b0;
               if (r_ff == RW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               rsp_bad_in     = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // row memory, one synchronous read port and one write port
   always_ff @(posedge clock) begin
      if (fill_we) begin
         mem[fill_cnt_ff] <= pas_ff;
      end
      rd_row_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         set_size_ff   <= SET_SIZE_RST;
         pick_count_ff <= PICK_COUNT_RST;
         fill_cnt_ff   <= '0;
         pas_ff        <= PAS_ROW0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         set_size_ff   <= set_size_in;
         pick_count_ff <= pick_count_in;
         fill_cnt_ff   <= fill_cnt_in;
         pas_ff        <= pas_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      j_ff           <= j_in;
      r_ff           <= r_in;
      e_ff           <= e_in;
      bad_ff         <= bad_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

endmodule

[rtl/cud_checker.sv]
// port-level checks for the combination unrank decoder, bound to its top level
// depends on cud_pkg and combination_unrank_decoder_unit_macros.svh
`include "combination_unrank_decoder_unit_macros.svh"

module cud_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [cud_pkg::VAL_W-1:0]         req_code,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [cud_pkg::ELEM_W-1:0]        rsp_element,
   input logic                              rsp_last,
   input logic                              rsp_bad_input,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [cud_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [cud_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cud_pkg::*;

   logic stalled;
   logic csr_seen;

   assign stalled  = rsp_valid && !rsp_ready;
   assign csr_seen = csr_valid && csr_ready && (csr_index == CSR_SET_SIZE) && (csr_wdata != '0);

   // a stalled result transfer keeps its payload
   `CUD_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_element) && $stable(rsp_last) && $stable(rsp_bad_input), "rsp payload changed while stalled")

   // an error result is a single transfer with element zero
   `CUD_ASSERT_IMP(a_err_shape, clock, reset, rsp_valid && rsp_bad_input, rsp_last && (rsp_element == '0), "error result malformed")

   // a decoded element is never zero
   `CUD_ASSERT_IMP(a_elem_nonzero, clock, reset, rsp_valid && !rsp_bad_input, rsp_element != '0, "decoded element is zero")

   // the row fill pass keeps the request side closed straight after reset
   `CUD_ASSERT_ALWAYS(a_fill_closed, clock, !reset && $past(reset) && !csr_seen, !req_ready, "request taken during fill")

endmodule

bind combination_unrank_decoder_unit cud_checker u_cud_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_code      (req_code),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_element   (rsp_element),
   .rsp_last      (rsp_last),
   .rsp_bad_input (rsp_bad_input),
   .csr_valid     (csr_valid),
   .csr_ready     (csr_ready),
   .csr_index     (csr_index),
   .csr_wdata     (csr_wdata)
);

[tb/sv/tb_top.sv]
// self-checking bench for combination_unrank_decoder_unit: rank codes in, subset elements out
// depends on cud_pkg and the decoder rtl; predicts each element from its own binomial walk
module tb_top;
   import cud_pkg::*;

   localparam int MAX_N          = 32;
   localparam int MAX_K          = 16;
   localparam int RAND_PHASES    = 12;
   localparam int ITEMS_PER_SET  = 26;
   localparam int HOLD_PHASE     = 10;
   localparam int HOLD_CYCLES    = 400;
   localparam int QUIET_LIMIT    = 3000;
   localparam int END_CYCLES     = 40;

   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic              last;
      logic              bad_input;
   } subset_elem_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [VAL_W-1:0]      req_code = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ELEM_W-1:0]     rsp_element;
   logic                  rsp_last;
   logic                  rsp_bad_input;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_SET_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register copies used for prediction
   logic [N_W-1:0] set_size_now   = SET_SIZE_RST;
   logic [K_W-1:0] pick_count_now = PICK_COUNT_RST;

   logic [VAL_W-1:0] codes_to_send[$];
   subset_elem_type  elements_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request  = 1'b0;
   bit hold_done     = 1'b0;
   int hold_count    = 0;
   int quiet_cycles  = 0;
   int failures      = 0;
   int codes_taken   = 0;
   int elems_checked = 0;
   int rejects_seen  = 0;
   int settings_used = 0;

   combination_unrank_decoder_unit #(.MAX_N(MAX_N), .MAX_K(MAX_K)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_code(req_code),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_element(rsp_element),
      .rsp_last(rsp_last), .rsp_bad_input(rsp_bad_input),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic longint unsigned binomial(int unsigned a, int unsigned b);
      longint unsigned c;
      c = 1;
      if (b > a) return 0;
      if (2 * b > a) b = a - b;
      for (int unsigned i = 0; i < b; i++) c = c * (a - i) / (i + 1);
      return c;
   endfunction

   // greedy walk: smallest candidate whose binomial still fits the remaining rank
   function automatic void unrank_code(input logic [VAL_W-1:0] code);
      int unsigned     n, k, j;
      longint unsigned rem, c;
      n   = set_size_now;
      k   = pick_count_now;
      rem = code;
      j   = 1;
      if (n == 0 || n > MAX_N || k == 0 || k > MAX_K || k > n || rem >= binomial(n, k)) begin
         elements_due.push_back(subset_elem_type'{element: '0, last: 1'b1, bad_input: 1'b1});
         return;
      end
      for (int unsigned i = 0; i < k; i++) begin
         c = binomial(n - j, k - i);
         while (c > rem && j < n) begin
            j++;
            c = binomial(n - j, k - i);
         end
         rem -= c;
         elements_due.push_back(subset_elem_type'{element: ELEM_W'(j), last: (i + 1 == k),
                                                  bad_input: 1'b0});
         if (j < n) j++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            unrank_code(req_code);
            codes_taken++;
         end
         if (!req_valid || req_ready) begin
            if (codes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_code  <= codes_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         rsp_ready <= 1'b0;
         if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      subset_elem_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (elements_due.size() == 0) begin
            $error("unexpected transfer: element %0d last %0b bad_input %0b",
                   rsp_element, rsp_last, rsp_bad_input);
            failures++;
         end else begin
            want = elements_due.pop_front();
            elems_checked++;
            if (want.bad_input) rejects_seen++;
            if (rsp_element !== want.element) begin
               $error("element: expected %0d, got %0d", want.element, rsp_element);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               failures++;
            end
            if (rsp_bad_input !== want.bad_input) begin
               $error("bad_input: expected %0b, got %0b", want.bad_input, rsp_bad_input);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[combination_unrank_decoder_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SET_SIZE) set_size_now = data;
      else if (idx == CSR_PICK_COUNT) pick_count_now = data[K_W-1:0];
   endtask

   task automatic apply_setting(input int unsigned n, input int unsigned k);
      csr_write(CSR_SET_SIZE, CSR_DATA_W'(n));
      csr_write(CSR_PICK_COUNT, CSR_DATA_W'(k));
      settings_used++;
   endtask

   // sampled mid-cycle so that the driver's updates at the edge are already visible
   task automatic wait_drained();
      do @(negedge clock);
      while (codes_to_send.size() != 0 || req_valid || elements_due.size() != 0);
   endtask

   initial begin : stimulus
      int unsigned     n, k;
      longint unsigned span;
      bit              sane;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 6;
      recv_idle_pct = 87;

      // reset setting: extremes of the rank range, both sides of the bound
      codes_to_send.push_back(0);
      codes_to_send.push_back(601080389);
      codes_to_send.push_back(601080390);
      codes_to_send.push_back('1);
      wait_drained();
      // unused register indexes leave the setting alone
      csr_write(csr_index_type'(2), '1);
      csr_write(csr_index_type'(3), '0);
      codes_to_send.push_back(12345);
      wait_drained();

      apply_setting(1, 1);
      codes_to_send.push_back(0);
      codes_to_send.push_back(1);
      wait_drained();
      apply_setting(32, 1);
      codes_to_send.push_back(0);
      codes_to_send.push_back(31);
      codes_to_send.push_back(32);
      wait_drained();
      apply_setting(16, 16);
      codes_to_send.push_back(0);
      codes_to_send.push_back(1);
      wait_drained();
      apply_setting(32, 2);
      codes_to_send.push_back(495);
      codes_to_send.push_back(496);
      wait_drained();
      // settings that cannot decode: k above n, zero sizes, out-of-range sizes
      apply_setting(3, 4);
      codes_to_send.push_back(0);
      wait_drained();
      apply_setting(0, 5);
      codes_to_send.push_back(0);
      wait_drained();
      apply_setting(63, 16);
      codes_to_send.push_back(0);
      wait_drained();
      apply_setting(10, 0);
      codes_to_send.push_back(0);
      wait_drained();
      apply_setting(32, 20);
      codes_to_send.push_back(0);
      wait_drained();
      apply_setting(32, 63);
      codes_to_send.push_back(0);
      wait_drained();

      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p * 3 / RAND_PHASES)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (p == RAND_PHASES - 1) begin
            n = 32;
            k = 16;
         end else if ($urandom_range(9) == 0) begin
            n = $urandom_range(63);
            k = $urandom_range(31);
         end else begin
            n = $urandom_range(1, MAX_N);
            k = $urandom_range(1, (n < MAX_K) ? n : MAX_K);
         end
         apply_setting(n, k);
         sane = (n >= 1 && n <= MAX_N && k >= 1 && k <= MAX_K && k <= n);
         span = sane ? binomial(n, k) : 0;
         for (int i = 0; i < ITEMS_PER_SET; i++) begin
            if (sane && $urandom_range(9) != 0)
               codes_to_send.push_back(VAL_W'($urandom_range(32'(span - 1))));
            else
               codes_to_send.push_back(VAL_W'($urandom()));
         end
         // receiver stops for a long stretch so the decoder backs up
         if (p == HOLD_PHASE) hold_request = 1'b1;
         wait_drained();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (elements_due.size() != 0) begin
         $error("%0d expected elements never arrived", elements_due.size());
         failures++;
      end
      $display("decoded %0d codes under %0d register settings", codes_taken, settings_used);
      $display("checked %0d elements, %0d of them rejections", elems_checked, rejects_seen);
      if (failures == 0) begin
         $display("[combination_unrank_decoder_unit] OK");
      end else begin
         $display("[combination_unrank_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule

[combination_unrank_decoder_unit.f]
+incdir+rtl
rtl/cud_pkg.sv
rtl/combination_unrank_decoder_unit.sv
rtl/cud_checker.sv
tb/sv/tb_top.sv
